// File: rtl/core/adcavg_pkg.sv
// Shared constants, types and state codes for the ADC burst averager.
// No dependencies; every other file of the block imports this package.
package adcavg_pkg;

	localparam int SAMPLES    = 16;
	localparam int RAW_W      = 12;
	localparam int MV_W       = 12;
	localparam int PCT_W      = 15;
	localparam int IDX_W      = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int CNT_W      = $clog2(SAMPLES + 1);
	localparam int SUM_W      = $clog2(SAMPLES * 4095 + 1);

	localparam int FULL_MV    = 3100;
	localparam int ADC_MAX    = 4095;
	localparam int PCT_MAX    = 25600;

	// serial arithmetic units: largest dividend is 25600 * 4095
	localparam int DVD_W      = 27;
	localparam int DVS_W      = 12;
	localparam int MCD_W      = 15;
	localparam int MPR_W      = 12;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLED = 2'd0,
		CFG_DRY_MV  = 2'd1,
		CFG_WET_MV  = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_AVG,
		CS_MV_MUL,
		CS_MV_DIV,
		CS_PCT_MUL,
		CS_PCT_DIV
	} calc_state_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} burst_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             start;
		logic [MCD_W-1:0] mcand;
		logic [MPR_W-1:0] mplier;
	} mul_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] value;
	} unit_rsp_t;

endpackage

// File: rtl/core/adcavg_in_if.sv
// Attempt channel: one converter attempt per beat.
// Depends on adcavg_pkg for field widths.
interface adcavg_in_if import adcavg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw;
	logic             read_ok;

	modport source (output valid, output raw, output read_ok, input ready);
	modport sink (input valid, input raw, input read_ok, output ready);
endinterface

// File: rtl/core/adcavg_out_if.sv
// Result channel: one averaged reading per burst.
// Depends on adcavg_pkg for field widths.
interface adcavg_out_if import adcavg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             ok;
	logic [MV_W-1:0]  millivolts;
	logic             pct_valid;
	logic [PCT_W-1:0] pct_q8;

	modport source (output valid, output ok, output millivolts, output pct_valid,
		output pct_q8, input ready);
	modport sink (input valid, input ok, input millivolts, input pct_valid,
		input pct_q8, output ready);
endinterface

// File: rtl/core/adcavg_cfg_if.sv
// Register write channel: index plus data per beat.
// Depends on adcavg_pkg for field widths.
interface adcavg_cfg_if import adcavg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/adcavg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on adcavg_pkg (widths, request/response structs).
module adcavg_div import adcavg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output unit_rsp_t rsp
);
	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              fits;

	// dividend bits leave at the top of quo_q, quotient bits enter at the bottom
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(DVD_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = quo_q;
endmodule

// File: rtl/core/adcavg_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on adcavg_pkg (widths, request/response structs).
module adcavg_mul import adcavg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mul_req_t  req,
	output unit_rsp_t rsp
);
	localparam int STEP_W = $clog2(MPR_W + 1);

	logic [DVD_W-1:0]  acc_q;
	logic [DVD_W-1:0]  mcd_q;
	logic [MPR_W-1:0]  mpr_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(MPR_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mcd_q <= DVD_W'(req.mcand);
			mpr_q <= req.mplier;
		end else if (busy_q) begin
			if (mpr_q[0])
				acc_q <= acc_q + mcd_q;
			mcd_q <= {mcd_q[DVD_W-2:0], 1'b0};
			mpr_q <= {1'b0, mpr_q[MPR_W-1:1]};
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = acc_q;
endmodule

// File: rtl/core/adcavg_acc.sv
// Burst accumulator: sums successful raw values, counts them and the attempts.
// Depends on adcavg_pkg and adcavg_in_if.
module adcavg_acc import adcavg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         enabled,
	input  logic         hold,
	adcavg_in_if.sink    samp,
	output logic         burst_valid,
	output burst_t       burst
);
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic             burst_valid_q;
	burst_t           burst_q;
	logic             last;
	logic             accept;
	logic [SUM_W-1:0] sum_nx;
	logic [CNT_W-1:0] cnt_nx;

	// closing beat of a burst waits until the calc path and output are free
	assign last       = idx_q == IDX_W'(SAMPLES - 1);
	assign samp.ready = !(enabled && last && hold);
	assign accept     = samp.valid && samp.ready;

	always_comb begin
		sum_nx = sum_q + (samp.read_ok ? SUM_W'(samp.raw) : '0);
		cnt_nx = cnt_q + CNT_W'(samp.read_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q         <= '0;
			cnt_q         <= '0;
			idx_q         <= '0;
			burst_valid_q <= 1'b0;
		end else begin
			burst_valid_q <= 1'b0;
			if (accept) begin
				if (!enabled || last) begin
					sum_q <= '0;
					cnt_q <= '0;
					idx_q <= '0;
					burst_valid_q <= enabled;
				end else begin
					sum_q <= sum_nx;
					cnt_q <= cnt_nx;
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			burst_q.sum   <= sum_nx;
			burst_q.count <= cnt_nx;
		end
	end

	assign burst_valid = burst_valid_q;
	assign burst       = burst_q;
endmodule

// File: rtl/core/adcavg_calc.sv
// End-of-burst sequencer: average, millivolt scaling and Q8 percentage,
// on one shared serial divider and multiplier; holds the result register.
// Depends on adcavg_pkg, adcavg_out_if, adcavg_div and adcavg_mul.
module adcavg_calc import adcavg_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          burst_valid,
	input  burst_t        burst,
	input  logic [MV_W-1:0] dry_mv,
	input  logic [MV_W-1:0] wet_mv,
	adcavg_out_if.source  res,
	output logic          busy
);
	calc_state_t      state_q;
	calc_state_t      state_nx;
	div_req_t         div_req;
	mul_req_t         mul_req;
	unit_rsp_t        div_rsp;
	unit_rsp_t        mul_rsp;
	logic [MV_W-1:0]  mv_q;
	logic [MV_W-1:0]  mv_now;
	logic [MV_W-1:0]  span;
	logic [MV_W-1:0]  diff;
	logic             cal_ok;
	logic             above;
	logic             go_pct;
	logic             load;
	logic             ld_ok;
	logic [MV_W-1:0]  ld_mv;
	logic             ld_pv;
	logic [PCT_W-1:0] ld_pct;
	logic             res_valid_q;
	logic             res_ok_q;
	logic [MV_W-1:0]  res_mv_q;
	logic             res_pv_q;
	logic [PCT_W-1:0] res_pct_q;

	adcavg_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	adcavg_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));

	// percentage needs the divide only when the reading sits strictly between dry and wet
	always_comb begin
		mv_now = div_rsp.value[MV_W-1:0];
		cal_ok = wet_mv > dry_mv;
		span   = wet_mv - dry_mv;
		above  = mv_now > dry_mv;
		diff   = mv_now - dry_mv;
		go_pct = cal_ok && above && (diff < span);
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			CS_IDLE:
				if (burst_valid && burst.count != '0)
					state_nx = CS_AVG;
			CS_AVG:
				if (div_rsp.done)
					state_nx = CS_MV_MUL;
			CS_MV_MUL:
				if (mul_rsp.done)
					state_nx = CS_MV_DIV;
			CS_MV_DIV:
				if (div_rsp.done)
					state_nx = go_pct ? CS_PCT_MUL : CS_IDLE;
			CS_PCT_MUL:
				if (mul_rsp.done)
					state_nx = CS_PCT_DIV;
			CS_PCT_DIV:
				if (div_rsp.done)
					state_nx = CS_IDLE;
			default:
				state_nx = CS_IDLE;
		endcase
	end

	always_comb begin
		div_req = '0;
		mul_req = '0;
		load    = 1'b0;
		ld_ok   = 1'b0;
		ld_mv   = '0;
		ld_pv   = 1'b0;
		ld_pct  = '0;
		unique case (state_q)
			CS_IDLE:
				if (burst_valid) begin
					if (burst.count == '0) begin
						load = 1'b1;
					end else begin
						div_req.start    = 1'b1;
						div_req.dividend = DVD_W'(burst.sum);
						div_req.divisor  = DVS_W'(burst.count);
					end
				end
			CS_AVG:
				if (div_rsp.done) begin
					mul_req.start  = 1'b1;
					mul_req.mcand  = MCD_W'(FULL_MV);
					mul_req.mplier = div_rsp.value[MPR_W-1:0];
				end
			CS_MV_MUL:
				if (mul_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = mul_rsp.value;
					div_req.divisor  = DVS_W'(ADC_MAX);
				end
			CS_MV_DIV:
				if (div_rsp.done) begin
					if (go_pct) begin
						mul_req.start  = 1'b1;
						mul_req.mcand  = MCD_W'(PCT_MAX);
						mul_req.mplier = diff;
					end else begin
						load   = 1'b1;
						ld_ok  = 1'b1;
						ld_mv  = mv_now;
						ld_pv  = cal_ok;
						ld_pct = (cal_ok && above) ? PCT_W'(PCT_MAX) : '0;
					end
				end
			CS_PCT_MUL:
				if (mul_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = mul_rsp.value;
					div_req.divisor  = span;
				end
			CS_PCT_DIV:
				if (div_rsp.done) begin
					load   = 1'b1;
					ld_ok  = 1'b1;
					ld_mv  = mv_q;
					ld_pv  = 1'b1;
					ld_pct = div_rsp.value[PCT_W-1:0];
				end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CS_MV_DIV && div_rsp.done)
			mv_q <= mv_now;
		if (load) begin
			res_ok_q  <= ld_ok;
			res_mv_q  <= ld_mv;
			res_pv_q  <= ld_pv;
			res_pct_q <= ld_pct;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.ok         = res_ok_q;
	assign res.millivolts = res_mv_q;
	assign res.pct_valid  = res_pv_q;
	assign res.pct_q8     = res_pct_q;
	assign busy           = (state_q != CS_IDLE) || res_valid_q;
endmodule

// File: rtl/core/adc_average_two_point_percent.sv
// ADC burst averager with two-point moisture percentage. Attempts are taken one per
// cycle unless a closing attempt is held; every SAMPLES attempts close a burst and
// yield one result (ok, millivolts, pct_valid, pct_q8). At the end of a burst the
// result is worked out on one shared bit-serial divider and multiplier: average,
// scale to mV, then the Q8 percent; the percent passes are skipped when the percent
// is clamped or invalid, and a burst with no good attempt loads an all-zero result.
// Attempts of the next burst keep being accepted meanwhile; only its closing
// attempt waits until the previous result has left the output register. Registers are
// written through cfg (always ready); the user must write them only while the block is
// idle, which the block does not enforce. Clearing enabled drops attempts and restarts.
// Depends on adcavg_pkg, the three channel interfaces, adcavg_acc and adcavg_calc.
module adc_average_two_point_percent import adcavg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	adcavg_cfg_if.sink   cfg,
	adcavg_in_if.sink    samp,
	adcavg_out_if.source res
);
	logic            enabled_q;
	logic [MV_W-1:0] dry_mv_q;
	logic [MV_W-1:0] wet_mv_q;
	logic            burst_valid;
	burst_t          burst;
	logic            calc_busy;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			dry_mv_q  <= '0;
			wet_mv_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_ENABLED: enabled_q <= cfg.data[0];
				CFG_DRY_MV:  dry_mv_q  <= cfg.data[MV_W-1:0];
				CFG_WET_MV:  wet_mv_q  <= cfg.data[MV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	adcavg_acc u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.enabled    (enabled_q),
		.hold       (calc_busy || burst_valid),
		.samp       (samp),
		.burst_valid(burst_valid),
		.burst      (burst)
	);

	adcavg_calc u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.burst_valid(burst_valid),
		.burst      (burst),
		.dry_mv     (dry_mv_q),
		.wet_mv     (wet_mv_q),
		.res        (res),
		.busy       (calc_busy)
	);
endmodule

// File: rtl/core/adcavg_chk.sv
// Port-level checks on the result channel of the burst averager.
// Depends on adcavg_pkg; bound to adc_average_two_point_percent below.
module adcavg_chk import adcavg_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_ready,
	input logic             res_ok,
	input logic [MV_W-1:0]  res_mv,
	input logic             res_pv,
	input logic [PCT_W-1:0] res_pct
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_ok) && $stable(res_mv)
			&& $stable(res_pv) && $stable(res_pct))
		else $error("result beat changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ok |-> res_mv == '0 && !res_pv && res_pct == '0)
		else $error("failed burst carries nonzero fields");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_pct <= PCT_W'(PCT_MAX))
		else $error("percentage above full scale");

	a_pct_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_pv |-> res_pct == '0)
		else $error("percentage set without valid calibration");

	a_mv_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_mv <= MV_W'(FULL_MV))
		else $error("millivolts above full scale");
endmodule

bind adc_average_two_point_percent adcavg_chk u_adcavg_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_ok   (res.ok),
	.res_mv   (res.millivolts),
	.res_pv   (res.pct_valid),
	.res_pct  (res.pct_q8)
);

// File: tb/sv/adcavg_reading_checker.sv
// Checker for the ADC burst averager: follows register writes and attempts, predicts
// each burst's reading and compares it with what leaves the result channel.
// Depends on adcavg_pkg and the three channel interfaces.
module adcavg_reading_checker import adcavg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	adcavg_cfg_if cfg,
	adcavg_in_if  samp,
	adcavg_out_if res,
	output int    errors,
	output int    outstanding
);

	typedef struct packed {
		logic             ok;
		logic [MV_W-1:0]  millivolts;
		logic             pct_valid;
		logic [PCT_W-1:0] pct_q8;
	} reading_t;

	reading_t                pending_readings[$];
	logic                    armed;
	logic [CFG_DATA_W-1:0]   dry_level;
	logic [CFG_DATA_W-1:0]   wet_level;
	int unsigned             raw_total;
	int unsigned             good_attempts;
	int unsigned             attempts_seen;

	function automatic reading_t predict_reading(int unsigned total, int unsigned good,
			logic [CFG_DATA_W-1:0] dry, logic [CFG_DATA_W-1:0] wet);
		reading_t    r;
		int unsigned avg;
		int unsigned mv;
		longint unsigned quot;
		r = '0;
		if (good != 0) begin
			avg = total / good;
			mv = (avg * FULL_MV) / ADC_MAX;
			r.ok = 1'b1;
			r.millivolts = mv[MV_W-1:0];
			if (wet > dry) begin
				r.pct_valid = 1'b1;
				if (mv > dry) begin
					quot = (64'(PCT_MAX) * 64'(mv - dry)) / 64'(wet - dry);
					r.pct_q8 = (quot > PCT_MAX) ? PCT_W'(PCT_MAX) : PCT_W'(quot);
				end
			end
		end
		return r;
	endfunction

	task automatic note_mismatch(string what, reading_t want, reading_t got);
		errors = errors + 1;
		if (errors <= 10) begin
			$write("%0t: %s: expected ok=%0d mv=%0d pct_valid=%0d pct_q8=%0d",
				$time, what, want.ok, want.millivolts, want.pct_valid, want.pct_q8);
			$display(", got ok=%0d mv=%0d pct_valid=%0d pct_q8=%0d",
				got.ok, got.millivolts, got.pct_valid, got.pct_q8);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t seen;
		reading_t want;
		if (!arst_n) begin
			pending_readings.delete();
			armed = 1'b0;
			dry_level = '0;
			wet_level = '0;
			raw_total = 0;
			good_attempts = 0;
			attempts_seen = 0;
			errors = 0;
			outstanding = 0;
		end else begin
			// result beats first, so a burst closing in the same cycle queues behind
			if (res.valid && res.ready) begin
				seen = '{res.ok, res.millivolts, res.pct_valid, res.pct_q8};
				if (pending_readings.size() == 0)
					note_mismatch("unexpected reading", '0, seen);
				else begin
					want = pending_readings.pop_front();
					if (seen !== want)
						note_mismatch("reading mismatch", want, seen);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_ENABLED: armed = cfg.data[0];
					CFG_DRY_MV:  dry_level = cfg.data;
					CFG_WET_MV:  wet_level = cfg.data;
					default: ;
				endcase
			end
			if (samp.valid && samp.ready) begin
				if (!armed) begin
					raw_total = 0;
					good_attempts = 0;
					attempts_seen = 0;
				end else begin
					if (samp.read_ok) begin
						raw_total = raw_total + samp.raw;
						good_attempts = good_attempts + 1;
					end
					attempts_seen = attempts_seen + 1;
					if (attempts_seen == SAMPLES) begin
						pending_readings.push_back(predict_reading(raw_total, good_attempts,
							dry_level, wet_level));
						raw_total = 0;
						good_attempts = 0;
						attempts_seen = 0;
					end
				end
			end
			outstanding = pending_readings.size();
		end
	end

endmodule

// File: tb/sv/testbench.sv
// Top of the ADC burst averager testbench: clock, reset, register writes, attempt
// stimulus with random idling, watchdog and verdict.
// Depends on adcavg_pkg, the channel interfaces, the block and adcavg_reading_checker.
module testbench;
	import adcavg_pkg::*;

	localparam int CALC_CYCLES = 200;
	localparam int STALL_LIMIT = 5000;

	logic clk;
	logic arst_n;
	int   sender_idle_pct = 0;
	int   receiver_stall_pct = 0;
	int   quiet_cycles = 0;
	int   errors;
	int   outstanding;

	adcavg_cfg_if cfg();
	adcavg_in_if  samp();
	adcavg_out_if res();

	adc_average_two_point_percent DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.samp   (samp),
		.res    (res)
	);

	adcavg_reading_checker u_readings (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.samp        (samp),
		.res         (res),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(negedge clk) begin
		res.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// nothing accepted on any channel for too long means the block is stuck
	always @(posedge clk) begin
		if ((cfg.valid && cfg.ready) || (samp.valid && samp.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic send_attempt(logic [RAW_W-1:0] value, logic good);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			samp.valid <= 1'b0;
			@(negedge clk);
		end
		samp.valid <= 1'b1;
		samp.raw <= value;
		samp.read_ok <= good;
		do @(posedge clk); while (!samp.ready);
	endtask

	// drop valid, let every queued reading drain, then let the datapath go quiet
	task automatic wait_idle();
		@(negedge clk);
		samp.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (CALC_CYCLES) @(negedge clk);
	endtask

	task automatic send_burst();
		int                 style;
		int                 lucky;
		logic [RAW_W-1:0]   level;
		style = $urandom_range(9);
		lucky = $urandom_range(SAMPLES - 1);
		level = RAW_W'($urandom_range(4095));
		if (style == 7)
			level = $urandom_range(1) ? RAW_W'(ADC_MAX) : '0;
		for (int k = 0; k < SAMPLES; k++) begin
			case (style)
				0, 1, 2, 3: send_attempt(RAW_W'($urandom_range(4095)),
					$urandom_range(3) != 0);
				4:          send_attempt(RAW_W'($urandom_range(4095)), 1'b0);
				5, 6, 7:    send_attempt(level, 1'b1);
				8:          send_attempt(RAW_W'($urandom_range(4095)), k == lucky);
				default:    send_attempt(RAW_W'($urandom_range(4095)),
					1'($urandom_range(1)));
			endcase
		end
	endtask

	initial begin
		int                    dry_plan[8];
		int                    wet_plan[8];
		logic [CFG_DATA_W-1:0] dry;
		logic [CFG_DATA_W-1:0] wet;
		// negative entries are drawn at random
		dry_plan = '{0, 3300, 1200, 4095, 0, -1, 1, -1};
		wet_plan = '{3300, 0, 1200, 4095, 4095, -1, 2, -1};
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_ENABLED;
		cfg.data = '0;
		samp.valid = 1'b0;
		samp.raw = '0;
		samp.read_ok = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// disabled out of reset: these are dropped
		send_attempt(RAW_W'(ADC_MAX), 1'b1);
		send_attempt('0, 1'b0);
		wait_idle();
		write_reg(CFG_ENABLED, CFG_DATA_W'(1));
		write_reg(CFG_DRY_MV, CFG_DATA_W'(500));
		write_reg(CFG_WET_MV, CFG_DATA_W'(2500));
		// a burst with no good attempt reads all zero
		for (int k = 0; k < SAMPLES; k++)
			send_attempt((k % 2) ? RAW_W'(ADC_MAX) : '0, 1'b0);
		// partial burst, then a disabled attempt restarts it
		repeat (5) send_attempt(RAW_W'(ADC_MAX), 1'b1);
		wait_idle();
		write_reg(CFG_ENABLED, CFG_DATA_W'(0));
		send_attempt(RAW_W'(ADC_MAX), 1'b1);

		for (int p = 0; p < 8; p++) begin
			wait_idle();
			if (p == 5) begin
				write_reg(CFG_ENABLED, CFG_DATA_W'(0));
				repeat (3) send_attempt(RAW_W'($urandom_range(4095)),
					1'($urandom_range(1)));
				wait_idle();
			end
			dry = (dry_plan[p] < 0) ? CFG_DATA_W'($urandom_range(3100))
				: CFG_DATA_W'(dry_plan[p]);
			if (wet_plan[p] >= 0)
				wet = CFG_DATA_W'(wet_plan[p]);
			else if (p == 5)
				wet = dry + CFG_DATA_W'($urandom_range(1, 800));
			else
				wet = CFG_DATA_W'($urandom_range(4095));
			write_reg(CFG_ENABLED, CFG_DATA_W'(1));
			write_reg(CFG_DRY_MV, dry);
			write_reg(CFG_WET_MV, wet);
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 67;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 67;
				end
				default: begin
					sender_idle_pct = 33;
					receiver_stall_pct = 33;
				end
			endcase
			repeat (7) send_burst();
			// leave a partial burst open across the next register change
			if (p % 2)
				repeat ($urandom_range(SAMPLES - 1))
					send_attempt(RAW_W'($urandom_range(4095)), 1'($urandom_range(1)));
		end
		wait_idle();

		if (errors == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
rtl/core/adcavg_pkg.sv
rtl/core/adcavg_in_if.sv
rtl/core/adcavg_out_if.sv
rtl/core/adcavg_cfg_if.sv
rtl/core/adcavg_div.sv
rtl/core/adcavg_mul.sv
rtl/core/adcavg_acc.sv
rtl/core/adcavg_calc.sv
rtl/core/adc_average_two_point_percent.sv
rtl/core/adcavg_chk.sv
tb/sv/adcavg_reading_checker.sv
tb/sv/testbench.sv
